// ----- rtl/core/vgc_pkg.sv -----
// Package for the vertex ground contour block: payload structs, codes and map size.
// Used by vertex_ground_contour_core and its checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vgc_pkg;

  // Heightmap size in tiles; one tile spans 128 scene units.
  localparam int MAP_TILES_X = 128;
  localparam int MAP_TILES_Z = 128;
  localparam int TILE_SHIFT  = 7;

  // Input item opcodes.
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_REPLY  = 1'b1;

  // Result commands.
  localparam logic [1:0] CMD_FETCH_GROUND = 2'd0;
  localparam logic [1:0] CMD_FETCH_ABOVE  = 2'd1;
  localparam logic [1:0] CMD_SET_Y        = 2'd2;

  // Operating modes.
  localparam logic [2:0] MODE_FOLLOW    = 3'd0;
  localparam logic [2:0] MODE_THRESHOLD = 3'd1;
  localparam logic [2:0] MODE_MODEL_Y   = 3'd2;
  localparam logic [2:0] MODE_ABOVE     = 3'd3;
  localparam logic [2:0] MODE_DUAL      = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_SCENE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_PLANE_LEVEL  = 3'd3;
  localparam logic [2:0] REG_USED_COUNT   = 3'd4;
  localparam logic [2:0] REG_LOWEST_Y     = 3'd5;
  localparam logic [2:0] REG_Y_SPAN       = 3'd6;

  // Reply phase codes.
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_PRIMARY   = 2'd1;
  localparam logic [1:0] PH_SECONDARY = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic        [15:0] vertex_number;
    logic signed [15:0] scene_x_pos;
    logic signed [15:0] scene_z_pos;
    logic signed [15:0] model_y;
    logic signed [15:0] height_value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [15:0] fetch_x;
    logic signed [15:0] fetch_z;
    logic        [1:0]  fetch_level;
    logic        [15:0] target_vertex;
    logic signed [31:0] new_y;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/vertex_ground_contour_core.sv -----
// Top level of the vertex ground contour block: sequencer, shared divider and multiplier.
// Depends on vgc_pkg for payload structs and codes.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage: items enter on the in channel (valid/ready), results leave on the out
// channel (valid/ready), and registers are written on the cfg channel, which is
// always ready. A vertex beat is answered by a fetch request or a set-Y result;
// a height reply beat yields the next fetch or the final Y. Stray replies and
// undefined modes give no result.
// The block works on one item at a time and drops in_ready_o while busy.
// Direct answers pass through the sequencer result register to the output register.
// Each signed division runs on one shared restoring divider at one quotient bit
// a cycle, with setup before and sign fix after. The threshold blend runs a
// division on each beat, and on its final step a division, a multiply and a
// second division; the dual level blend divides and multiplies on its last reply.
// A finished result sits in the output register while the next item is taken;
// if the receiver stalls, a second result waits in the sequencer until the
// output register frees up.
// Reset returns the configuration and control registers to their reset values:
// mode model Y, used count 1.
//
module vertex_ground_contour_core
  import vgc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Configuration registers.
  logic [2:0]  mode_q;
  logic [31:0] thr_q;
  logic [15:0] sh_q, used_q, lo_q, span_q;
  logic [1:0]  plane_q;

  // Item state.
  logic [2:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic        step_q, step_d;
  logic [15:0] idx_q, idx_d, x_q, x_d, z_q, z_d, y_q, y_d, g_q, g_d, a_q, a_d;
  out_item_t   res_q, res_d, out_q;
  logic        out_valid_q;
  logic [31:0] prod_q, prod_d;

  // Divider state.
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [31:0] y32, g32, a32, sh32, q32, div_a, div_b, mul_a, mul_b, mul_p;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        div_go, out_load, skip, x_in, z_in;

  assign y32  = {{16{y_q[15]}}, y_q};
  assign g32  = {{16{g_q[15]}}, g_q};
  assign a32  = {{16{a_q[15]}}, a_q};
  assign sh32 = {{16{sh_q[15]}}, sh_q};
  assign q32  = neg_q ? 32'(-quo_q) : quo_q;

  // Bounds check on the tile of the held vertex.
  assign x_in = !x_q[15] && (32'(x_q[14:TILE_SHIFT]) < 32'(MAP_TILES_X - 1));
  assign z_in = !z_q[15] && (32'(z_q[14:TILE_SHIFT]) < 32'(MAP_TILES_Z - 1));
  assign skip = (idx_q >= used_q) && !(x_in && z_in);

  // Shared multiplier, low 32 bits kept.
  assign mul_p = mul_a * mul_b;

  // One restoring division step.
  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};

  function automatic out_item_t mk_set(logic [15:0] idx, logic [31:0] y);
    out_item_t r;
    r = '0;
    r.command       = CMD_SET_Y;
    r.target_vertex = idx;
    r.new_y         = y;
    return r;
  endfunction

  function automatic out_item_t mk_fetch(logic [1:0] cmd, logic [15:0] x, logic [15:0] z,
                                         logic [1:0] lvl);
    out_item_t r;
    r = '0;
    r.command     = cmd;
    r.fetch_x     = x;
    r.fetch_z     = z;
    r.fetch_level = lvl;
    return r;
  endfunction

  // Sequencer.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    step_d  = step_q;
    idx_d   = idx_q;
    x_d     = x_q;
    z_d     = z_q;
    y_d     = y_q;
    g_d     = g_q;
    a_d     = a_q;
    res_d   = res_q;
    prod_d  = prod_q;
    div_go  = 1'b0;
    div_a   = '0;
    div_b   = '0;
    mul_a   = q32;
    mul_b   = 32'(g32 - a32);
    if (mode_q == MODE_THRESHOLD) begin
      mul_a = 32'(g32 - sh32);
      mul_b = 32'(thr_q - q32);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.opcode == OP_VERTEX) begin
            idx_d   = in_data_i.vertex_number;
            x_d     = in_data_i.scene_x_pos;
            z_d     = in_data_i.scene_z_pos;
            y_d     = in_data_i.model_y;
            phase_d = PH_IDLE;
            sub_d   = 2'd0;
            state_d = S_START;
          end else if (phase_q != PH_IDLE) begin
            state_d = S_START;
            sub_d   = 2'd1;
            case (mode_q) inside
              MODE_FOLLOW, MODE_THRESHOLD: g_d = in_data_i.height_value;
              MODE_ABOVE:                  a_d = in_data_i.height_value;
              MODE_DUAL: begin
                if (phase_q == PH_PRIMARY) begin
                  g_d = in_data_i.height_value;
                end else begin
                  a_d   = in_data_i.height_value;
                  sub_d = 2'd2;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end
      S_START: begin
        state_d = S_OUT;
        phase_d = PH_IDLE;
        res_d   = mk_set(idx_q, y32);
        unique case (mode_q)
          MODE_FOLLOW: begin
            if (sub_q != 2'd0) begin
              res_d = mk_set(idx_q, 32'(y32 + g32 - sh32));
            end else if (!skip) begin
              res_d   = mk_fetch(CMD_FETCH_GROUND, x_q, z_q, plane_q);
              phase_d = PH_PRIMARY;
            end
          end
          MODE_THRESHOLD: begin
            if (lo_q != '0) begin
              div_go  = 1'b1;
              div_a   = {y_q, 16'b0};
              div_b   = {{16{lo_q[15]}}, lo_q};
              step_d  = 1'b0;
              state_d = S_DIV;
            end
          end
          MODE_MODEL_Y: ;
          MODE_ABOVE: begin
            if (sub_q == 2'd0) begin
              res_d   = mk_fetch(CMD_FETCH_ABOVE, x_q, z_q, plane_q);
              phase_d = PH_PRIMARY;
            end else begin
              res_d = mk_set(idx_q, 32'(y32 + a32 - sh32 + {16'b0, span_q}));
            end
          end
          MODE_DUAL: begin
            if (span_q != '0) begin
              if (sub_q == 2'd0) begin
                res_d   = mk_fetch(CMD_FETCH_GROUND, x_q, z_q, plane_q);
                phase_d = PH_PRIMARY;
              end else if (sub_q == 2'd1) begin
                res_d   = mk_fetch(CMD_FETCH_ABOVE, x_q, z_q, plane_q);
                phase_d = PH_SECONDARY;
              end else begin
                div_go  = 1'b1;
                div_a   = {{8{y_q[15]}}, y_q, 8'b0};
                div_b   = {16'b0, span_q};
                state_d = S_DIV;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        state_d = S_OUT;
        res_d   = mk_set(idx_q, y32);
        if (mode_q == MODE_THRESHOLD) begin
          if (step_q) begin
            res_d = mk_set(idx_q, 32'(y32 + q32));
          end else if (sub_q == 2'd0) begin
            if (!($signed(q32) >= $signed(thr_q) || skip)) begin
              res_d   = mk_fetch(CMD_FETCH_GROUND, x_q, z_q, plane_q);
              phase_d = PH_PRIMARY;
            end
          end else if (thr_q != '0) begin
            state_d = S_MUL;
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = mul_p;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (mode_q == MODE_THRESHOLD) begin
          div_go  = 1'b1;
          div_a   = prod_q;
          div_b   = thr_q;
          step_d  = 1'b1;
          state_d = S_DIV;
        end else begin
          res_d   = mk_set(idx_q, 32'({{8{prod_q[31]}}, prod_q[31:8]} - sh32 + g32));
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Divider setup and iteration.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    if (div_go) begin
      rem_d = '0;
      quo_d = div_a[31] ? 32'(-div_a) : div_a;
      dvs_d = div_b[31] ? 32'(-div_b) : div_b;
      neg_d = div_a[31] ^ div_b[31];
      cnt_d = '0;
    end else if (state_q == S_DIV) begin
      cnt_d = 5'(cnt_q + 5'd1);
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_MODEL_Y;
      thr_q       <= '0;
      sh_q        <= '0;
      plane_q     <= '0;
      used_q      <= 16'd1;
      lo_q        <= '0;
      span_q      <= '0;
      idx_q       <= '0;
      x_q         <= '0;
      z_q         <= '0;
      y_q         <= '0;
      g_q         <= '0;
      a_q         <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      x_q     <= x_d;
      z_q     <= z_d;
      y_q     <= y_d;
      g_q     <= g_d;
      a_q     <= a_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MODE:         mode_q  <= cfg_data_i[2:0];
          REG_THRESHOLD:    thr_q   <= cfg_data_i;
          REG_SCENE_HEIGHT: sh_q    <= cfg_data_i[15:0];
          REG_PLANE_LEVEL:  plane_q <= cfg_data_i[1:0];
          REG_USED_COUNT:   used_q  <= cfg_data_i[15:0];
          REG_LOWEST_Y:     lo_q    <= cfg_data_i[15:0];
          REG_Y_SPAN:       span_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sub_q  <= sub_d;
    step_q <= step_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vgc_checker.sv -----
// Port checker for vertex_ground_contour_core, bound to the top level.
// Depends on vgc_pkg for the payload structs and command codes.
`timescale 1ns / 1ps
`default_nettype none

module vgc_checker
  import vgc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o,
  input wire logic      cfg_ready_o
);

  // A result beat holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // An offered input beat stays offered until the block takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input beat withdrawn before it was taken");

  // Only defined commands leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.command == CMD_FETCH_GROUND ||
                    out_data_o.command == CMD_FETCH_ABOVE ||
                    out_data_o.command == CMD_SET_Y)
    else $error("undefined command on output");

  // Fetch requests carry no vertex Y.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command != CMD_SET_Y |-> out_data_o.new_y == '0 &&
      cfg_ready_o)
    else $error("fetch request with nonzero Y");

endmodule

bind vertex_ground_contour_core vgc_checker u_vgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

// ----- sim/vertex_ground_contour_core_tb.sv -----
// Self-checking testbench for vertex_ground_contour_core: directed and random vertex and reply beats.
// Depends on vgc_pkg and the core RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module vertex_ground_contour_core_tb
  import vgc_pkg::*;
();

  // Scoreboard: mirrors the register file and reply sequencing, queues predicted results.
  class contour_scoreboard;
    logic [2:0]  mode_q;
    logic [31:0] thresh_q;
    logic [15:0] scene_h_q;
    logic [1:0]  plane_q;
    logic [15:0] used_q;
    logic [15:0] lowest_q;
    logic [15:0] span_q;
    logic [1:0]  phase_q;
    in_item_t    held_q;
    logic [15:0] ground_q;
    logic [15:0] above_q;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      mode_q = MODE_MODEL_Y; thresh_q = '0; scene_h_q = '0; plane_q = '0;
      used_q = 16'd1; lowest_q = '0; span_q = '0; phase_q = PH_IDLE;
      held_q = '0; ground_q = '0; above_q = '0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:         mode_q = val[2:0];
        REG_THRESHOLD:    thresh_q = val;
        REG_SCENE_HEIGHT: scene_h_q = val[15:0];
        REG_PLANE_LEVEL:  plane_q = val[1:0];
        REG_USED_COUNT:   used_q = val[15:0];
        REG_LOWEST_Y:     lowest_q = val[15:0];
        REG_Y_SPAN:       span_q = val[15:0];
        default: ;
      endcase
    endfunction

    function void push_set(logic signed [31:0] y);
      out_item_t r;
      r = '0;
      r.command = CMD_SET_Y;
      r.target_vertex = held_q.vertex_number;
      r.new_y = y;
      pending_q.push_back(r);
      phase_q = PH_IDLE;
    endfunction

    function void push_fetch(logic [1:0] cmd, logic [1:0] nxt);
      out_item_t r;
      r = '0;
      r.command = cmd;
      r.fetch_x = held_q.scene_x_pos;
      r.fetch_z = held_q.scene_z_pos;
      r.fetch_level = plane_q;
      pending_q.push_back(r);
      phase_q = nxt;
    endfunction

    // Truncating 32-bit signed division with wrap (only min/-1 overflows).
    function logic signed [31:0] sdiv(longint a, longint b);
      longint q;
      q = a / b;
      return q[31:0];
    endfunction

    // Steps the sequencer; stage 0 before a fetch, 1 after primary, 2 after secondary.
    function void advance(int stage);
      longint y, sh, g, a, lo, thr, r, t, prod;
      logic signed [31:0] w, d;
      logic out_map;
      int tx, tz;
      y  = longint'($signed(held_q.model_y));
      sh = longint'($signed(scene_h_q));
      g  = longint'($signed(ground_q));
      a  = longint'($signed(above_q));
      tx = $signed(held_q.scene_x_pos) >>> TILE_SHIFT;
      tz = $signed(held_q.scene_z_pos) >>> TILE_SHIFT;
      out_map = !(tx >= 0 && tx < MAP_TILES_X - 1 && tz >= 0 && tz < MAP_TILES_Z - 1);
      case (mode_q)
        MODE_FOLLOW: begin
          if (stage == 0) begin
            if (held_q.vertex_number >= used_q && out_map) push_set(y[31:0]);
            else push_fetch(CMD_FETCH_GROUND, PH_PRIMARY);
          end else begin
            w = 32'(y + g - sh);
            push_set(w);
          end
        end
        MODE_THRESHOLD: begin
          lo  = longint'($signed(lowest_q));
          thr = longint'($signed(thresh_q));
          if (lo == 0) begin
            push_set(y[31:0]);
          end else begin
            w = 32'(y * 65536);
            r = longint'(sdiv(longint'(w), lo));
            if (stage == 0) begin
              if (r >= thr || (held_q.vertex_number >= used_q && out_map)) push_set(y[31:0]);
              else push_fetch(CMD_FETCH_GROUND, PH_PRIMARY);
            end else if (thr == 0) begin
              push_set(y[31:0]);
            end else begin
              d = 32'(thr - r);
              w = 32'((g - sh) * longint'(d));
              d = sdiv(longint'(w), thr);
              w = 32'(y + longint'(d));
              push_set(w);
            end
          end
        end
        MODE_MODEL_Y: push_set(y[31:0]);
        MODE_ABOVE: begin
          if (stage == 0) push_fetch(CMD_FETCH_ABOVE, PH_PRIMARY);
          else begin
            w = 32'(y + a - sh + longint'(span_q));
            push_set(w);
          end
        end
        MODE_DUAL: begin
          if (span_q == 0) push_set(y[31:0]);
          else if (stage == 0) push_fetch(CMD_FETCH_GROUND, PH_PRIMARY);
          else if (stage == 1) push_fetch(CMD_FETCH_ABOVE, PH_SECONDARY);
          else begin
            t = longint'(sdiv(y * 256, longint'(span_q)));
            w = 32'(t * (g - a));
            prod = longint'(w) >>> 8;
            w = 32'(prod - (sh - g));
            push_set(w);
          end
        end
        default: phase_q = PH_IDLE;
      endcase
    endfunction

    // Notes one accepted input beat.
    function void note_input(in_item_t it);
      if (it.opcode == OP_VERTEX) begin
        held_q = it;
        phase_q = PH_IDLE;
        advance(0);
      end else if (phase_q != PH_IDLE) begin
        case (mode_q) inside
          MODE_FOLLOW, MODE_THRESHOLD: begin ground_q = it.height_value; advance(1); end
          MODE_ABOVE: begin above_q = it.height_value; advance(1); end
          MODE_DUAL: begin
            if (phase_q == PH_PRIMARY) begin ground_q = it.height_value; advance(1); end
            else begin above_q = it.height_value; advance(2); end
          end
          default: phase_q = PH_IDLE;
        endcase
      end
    endfunction

    // Checks one accepted output beat against the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: %p", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.command !== e.command) begin
        $error("command: expected %0d, got %0d", e.command, got.command); errors++;
      end
      if (got.fetch_x !== e.fetch_x) begin
        $error("fetch_x: expected %0d, got %0d", e.fetch_x, got.fetch_x); errors++;
      end
      if (got.fetch_z !== e.fetch_z) begin
        $error("fetch_z: expected %0d, got %0d", e.fetch_z, got.fetch_z); errors++;
      end
      if (got.fetch_level !== e.fetch_level) begin
        $error("fetch_level: expected %0d, got %0d", e.fetch_level, got.fetch_level); errors++;
      end
      if (got.target_vertex !== e.target_vertex) begin
        $error("target_vertex: expected %0d, got %0d", e.target_vertex, got.target_vertex);
        errors++;
      end
      if (got.new_y !== e.new_y) begin
        $error("new_y: expected %0d, got %0d", e.new_y, got.new_y); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        stall_en;

  contour_scoreboard sb;

  vertex_ground_contour_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Result monitor: samples accepted output beats at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  // Drives one beat and waits for it to be accepted.
  task automatic send_beat(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Burst gaps: occasionally drop valid for a random number of cycles.
  task automatic maybe_gap();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Writes one register; valid drops for a cycle before the next write.
  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t rand_vertex(bit near_map);
    in_item_t it;
    it = '0;
    it.opcode = OP_VERTEX;
    it.vertex_number = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    if (near_map) begin
      it.scene_x_pos = 16'($urandom_range(0, 16500)) - 16'd100;
      it.scene_z_pos = 16'($urandom_range(0, 16500)) - 16'd100;
    end else begin
      it.scene_x_pos = 16'($urandom);
      it.scene_z_pos = 16'($urandom);
    end
    it.model_y = 16'($urandom);
    it.height_value = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t rand_reply();
    in_item_t it;
    it = '0;
    it.opcode = OP_REPLY;
    it.vertex_number = 16'($urandom);
    it.scene_x_pos = 16'($urandom);
    it.scene_z_pos = 16'($urandom);
    it.model_y = 16'($urandom);
    it.height_value = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    return it;
  endfunction

  // Random register setting for one phase.
  task automatic random_config(logic [2:0] m);
    logic [15:0] lo;
    write_cfg(REG_MODE, {29'd0, m});
    case ($urandom_range(0, 3))
      0: write_cfg(REG_THRESHOLD, 32'h7FFF_FFFF);
      1: write_cfg(REG_THRESHOLD, 32'h8000_0000);
      2: write_cfg(REG_THRESHOLD, $urandom);
      default: write_cfg(REG_THRESHOLD, 32'($signed($urandom_range(0, 400000)) - 200000));
    endcase
    write_cfg(REG_SCENE_HEIGHT, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000));
    write_cfg(REG_PLANE_LEVEL, $urandom_range(0, 3));
    write_cfg(REG_USED_COUNT, ($urandom_range(0, 4) == 0) ? 32'hFFFF : $urandom_range(1, 6));
    lo = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
    write_cfg(REG_LOWEST_Y, {16'd0, lo});
    write_cfg(REG_Y_SPAN, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535));
  endtask

  initial begin
    in_item_t it;
    logic [2:0] m;
    int sent;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    stall_en = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: stray reply and reset mode, then extremes under each mode.
    it = rand_reply(); send_beat(it);
    it = rand_vertex(1'b0); it.model_y = 16'sh8000; send_beat(it);
    in_valid <= 1'b0;
    drain();
    write_cfg(REG_THRESHOLD, 32'h0001_0000);
    write_cfg(REG_SCENE_HEIGHT, 32'h0000_8000);
    write_cfg(REG_PLANE_LEVEL, 32'd3);
    write_cfg(REG_USED_COUNT, 32'd2);
    write_cfg(REG_LOWEST_Y, 32'h0000_8000);
    write_cfg(REG_Y_SPAN, 32'h0000_FFFF);
    for (int k = 0; k < 8; k++) begin
      m = 3'(k);
      write_cfg(REG_MODE, {29'd0, m});
      it = rand_vertex(1'b1); it.vertex_number = 16'hFFFF; it.scene_x_pos = 16'sh7FFF;
      send_beat(it);
      it = rand_vertex(1'b1); it.vertex_number = 16'd0; it.model_y = 16'sh7FFF; send_beat(it);
      it = rand_reply(); it.height_value = 16'sh8000; send_beat(it);
      it = rand_reply(); it.height_value = 16'sh7FFF; send_beat(it);
      in_valid <= 1'b0;
      drain();
    end

    // Random phases; mostly well-formed vertex/reply sequences.
    stall_en = 1'b1;
    sent = 0;
    while (sent < 800) begin
      m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      random_config(m);
      for (int n = 0; n < 40; n++) begin
        it = rand_vertex($urandom_range(0, 3) != 0);
        send_beat(it); maybe_gap();
        sent++;
        if ($urandom_range(0, 9) != 0) begin
          it = rand_reply(); send_beat(it); maybe_gap();
          sent++;
          if ($urandom_range(0, 5) != 0) begin
            it = rand_reply(); send_beat(it); maybe_gap();
            sent++;
          end
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending_q.size() != 0) $error("%0d results never arrived", sb.pending_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vgc_pkg.sv
rtl/core/vertex_ground_contour_core.sv
rtl/core/vgc_checker.sv
sim/vertex_ground_contour_core_tb.sv
